// ===== src/usbpdsnk_pkg.sv =====
// ----------------------------------------------------------------------------
// usbpdsnk_pkg
// Types, codes and reset values shared by the USB PD sink connection manager.
// ----------------------------------------------------------------------------
package usbpdsnk_pkg;

  // Widths of the fields and registers
  localparam int unsigned TimeW   = 48;
  localparam int unsigned DelayW  = 24;
  localparam int unsigned ObjW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // Stream widths, packed fields rounded up to whole bytes
  localparam int unsigned InBits   = 66;
  localparam int unsigned OutBits  = 45;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONNECT_DEBOUNCE    = 2'd0,
    CFG_DISCONNECT_DEBOUNCE = 2'd1,
    CFG_REQUEST_DELAY       = 2'd2,
    CFG_REQUEST_OBJECT      = 2'd3
  } cfg_idx_t;

  // Register reset values
  localparam logic [DelayW-1:0] ConnectDebounceRst    = 24'd150000;
  localparam logic [DelayW-1:0] DisconnectDebounceRst = 24'd50000;
  localparam logic [DelayW-1:0] RequestDelayRst       = 24'd1000;
  localparam logic [ObjW-1:0]   RequestObjectRst      = 32'h4303_20C8;

  // Received message types of interest
  localparam logic [4:0] MsgSourceCap = 5'd1;
  localparam logic [4:0] MsgAccept    = 5'd3;
  localparam logic [4:0] MsgPsReady   = 5'd6;

  // Port attach state
  typedef enum logic [1:0] {
    PORT_DISCONNECTED = 2'd0,
    PORT_ATTACH_DEB   = 2'd1,
    PORT_CONNECTED    = 2'd2,
    PORT_DETACH_DEB   = 2'd3
  } port_mode_t;

  // Power negotiation state
  typedef enum logic [2:0] {
    NEG_IDLE         = 3'd0,
    NEG_CAPS_RECEIVED = 3'd1,
    NEG_REQUEST_SENT = 3'd2,
    NEG_WAIT_ACCEPT  = 3'd3,
    NEG_WAIT_READY   = 3'd4,
    NEG_READY        = 3'd5
  } neg_mode_t;

  // Alert to clear
  typedef enum logic [2:0] {
    CLR_NONE       = 3'd0,
    CLR_CC         = 3'd1,
    CLR_RX         = 3'd2,
    CLR_HARD_RESET = 3'd3,
    CLR_TX_DONE    = 3'd4
  } clear_t;

  // Configuration register set
  typedef struct packed {
    logic [DelayW-1:0] connect_debounce_us;
    logic [DelayW-1:0] disconnect_debounce_us;
    logic [DelayW-1:0] request_delay_us;
    logic [ObjW-1:0]   request_data_object;
  } cfg_t;

  // One poll beat; last member sits in the lowest bits
  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic [2:0]       msg_object_count;
    logic [4:0]       msg_type;
    logic [1:0]       cc2_level;
    logic [1:0]       cc1_level;
    logic             cc_terminated;
    logic             alert_tx_done;
    logic             alert_hard_reset;
    logic             alert_rx_message;
    logic             alert_cc_change;
    logic             alert_pending;
  } in_item_t;

  // One result beat; last member sits in the lowest bits
  typedef struct packed {
    logic            halted;
    neg_mode_t       negotiation_state;
    port_mode_t      port_state;
    logic [ObjW-1:0] request_object;
    logic            send_request;
    logic            orientation;
    logic            commit_connection;
    logic            restart_detection;
    clear_t          clear_alert;
  } out_item_t;

  // A timer expires once now passes stamp plus delay (sum taken without wrap)
  function automatic logic timer_expired(input logic [TimeW-1:0]  now,
                                         input logic [TimeW-1:0]  stamp,
                                         input logic [DelayW-1:0] delay);
    logic [TimeW:0] limit;
    limit = {1'b0, stamp} + {{(TimeW - DelayW + 1){1'b0}}, delay};
    return {1'b0, now} > limit;
  endfunction

endpackage

// ===== src/usbpdsnk_cfg.sv =====
// ----------------------------------------------------------------------------
// usbpdsnk_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module usbpdsnk_cfg
  import usbpdsnk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output cfg_t               cfg
);

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connect_debounce_us    <= ConnectDebounceRst;
      cfg.disconnect_debounce_us <= DisconnectDebounceRst;
      cfg.request_delay_us       <= RequestDelayRst;
      cfg.request_data_object    <= RequestObjectRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CONNECT_DEBOUNCE:    cfg.connect_debounce_us    <= cfg_data[DelayW-1:0];
        CFG_DISCONNECT_DEBOUNCE: cfg.disconnect_debounce_us <= cfg_data[DelayW-1:0];
        CFG_REQUEST_DELAY:       cfg.request_delay_us       <= cfg_data[DelayW-1:0];
        CFG_REQUEST_OBJECT:      cfg.request_data_object    <= cfg_data[ObjW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/usbpdsnk_in_reg.sv =====
// ----------------------------------------------------------------------------
// usbpdsnk_in_reg
// Input register: holds one poll beat until the core takes it.
// ----------------------------------------------------------------------------
module usbpdsnk_in_reg
  import usbpdsnk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     held_valid,
  output in_item_t held_item,
  input  logic     take
);

  // Free when empty or when the held beat leaves this cycle
  assign in_ready = !held_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== src/usbpdsnk_core.sv =====
// ----------------------------------------------------------------------------
// usbpdsnk_core
// Port and negotiation state, single-pass alert and timer logic, result register.
// ----------------------------------------------------------------------------
module usbpdsnk_core
  import usbpdsnk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      held_valid,
  input  in_item_t  held_item,
  output logic      take,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_item
);

  port_mode_t       port_mode, port_mode_next;
  neg_mode_t        contract_mode, contract_mode_next;
  logic [TimeW-1:0] event_time, event_time_next;
  logic             stopped, stopped_next;
  out_item_t        result;

  // Take a beat when the result register is free or being drained
  assign take = held_valid && (!res_valid || res_ready);

  // Handle the first alert, then check the timers
  always_comb begin
    port_mode_next     = port_mode;
    contract_mode_next = contract_mode;
    event_time_next    = event_time;
    stopped_next       = stopped;
    result             = '0;
    result.clear_alert = CLR_NONE;

    if (!stopped) begin
      if (held_item.alert_pending) begin
        if (held_item.alert_cc_change) begin
          case (port_mode)
            PORT_DISCONNECTED: begin
              if (held_item.cc_terminated) begin
                port_mode_next     = PORT_ATTACH_DEB;
                event_time_next    = held_item.now_us;
                result.clear_alert = CLR_CC;
              end else begin
                stopped_next = 1'b1;
              end
            end
            PORT_ATTACH_DEB: begin
              port_mode_next           = PORT_DISCONNECTED;
              contract_mode_next       = NEG_IDLE;
              result.restart_detection = 1'b1;
              result.clear_alert       = CLR_CC;
            end
            PORT_CONNECTED: begin
              port_mode_next     = PORT_DETACH_DEB;
              event_time_next    = held_item.now_us;
              result.clear_alert = CLR_CC;
            end
            default: begin
              result.clear_alert = CLR_CC;
            end
          endcase
        end else if (held_item.alert_rx_message) begin
          if (port_mode == PORT_CONNECTED) begin
            result.clear_alert = CLR_RX;
            if (held_item.msg_object_count != 3'd0 && held_item.msg_type == MsgSourceCap) begin
              contract_mode_next = NEG_CAPS_RECEIVED;
              event_time_next    = held_item.now_us;
            end else if (contract_mode == NEG_WAIT_ACCEPT) begin
              if (held_item.msg_object_count == 3'd0 && held_item.msg_type == MsgAccept) begin
                contract_mode_next = NEG_WAIT_READY;
              end
            end else if (contract_mode == NEG_WAIT_READY) begin
              if (held_item.msg_object_count == 3'd0 && held_item.msg_type == MsgPsReady) begin
                contract_mode_next = NEG_READY;
              end
            end
          end
        end else if (held_item.alert_hard_reset) begin
          if (port_mode == PORT_CONNECTED) begin
            result.clear_alert = CLR_HARD_RESET;
          end
        end else if (held_item.alert_tx_done) begin
          result.clear_alert = CLR_TX_DONE;
          if (port_mode == PORT_CONNECTED && contract_mode == NEG_REQUEST_SENT) begin
            contract_mode_next = NEG_WAIT_ACCEPT;
          end
        end
      end

      // Timers see the state left by the alert
      if (!stopped_next) begin
        case (port_mode_next)
          PORT_ATTACH_DEB: begin
            if (timer_expired(held_item.now_us, event_time_next,
                              cfg.connect_debounce_us)) begin
              port_mode_next           = PORT_CONNECTED;
              result.commit_connection = 1'b1;
              result.orientation       = (held_item.cc2_level > 2'd1);
            end
          end
          PORT_DETACH_DEB: begin
            if (timer_expired(held_item.now_us, event_time_next,
                              cfg.disconnect_debounce_us)) begin
              port_mode_next = PORT_DISCONNECTED;
            end
          end
          PORT_CONNECTED: begin
            if (contract_mode_next == NEG_CAPS_RECEIVED &&
                timer_expired(held_item.now_us, event_time_next,
                              cfg.request_delay_us)) begin
              contract_mode_next    = NEG_REQUEST_SENT;
              result.send_request   = 1'b1;
              result.request_object = cfg.request_data_object;
            end
          end
          default: ;
        endcase
      end
    end

    result.port_state        = port_mode_next;
    result.negotiation_state = contract_mode_next;
    result.halted            = stopped_next;
  end

  // Advance state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      port_mode     <= PORT_DISCONNECTED;
      contract_mode <= NEG_IDLE;
      event_time    <= '0;
      stopped       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (take) begin
        port_mode     <= port_mode_next;
        contract_mode <= contract_mode_next;
        event_time    <= event_time_next;
        stopped       <= stopped_next;
        res_valid     <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      res_item <= result;
    end
  end

endmodule

// ===== src/usb_pd_sink_connection_manager_unit.sv =====
// ----------------------------------------------------------------------------
// usb_pd_sink_connection_manager_unit
// USB Type-C / PD sink connection manager: one poll beat in, one action beat out.
// ----------------------------------------------------------------------------
// Each beat on the s_ side is one poll of the port controller: alert bits,
// CC status, received header and the time in microseconds. Each poll gives
// exactly one beat on the m_ side: the alert to clear, detection restart,
// connection commit with orientation, power request send with its data
// object, and the port, negotiation and halt state after the poll.
// The configuration port writes the three timer delays and the request
// object; write it only while no poll is in flight.
// An accepted poll passes the input register, then the result register,
// before it shows on m_tdata. Throughput: one poll per cycle while m_tready
// is high, set by the single pass through the alert and timer logic; state
// is updated as each poll leaves the input register, so the next poll sees
// it.
// While m_tready is low, one result waits in the result register and one
// poll in the input register; s_tready then drops until the result drains.
// Reset clears the state to disconnected, idle, not halted, and loads the
// register defaults. After an unterminated CC change while disconnected, the
// block halts and reports only its state until the next reset.
// ----------------------------------------------------------------------------
module usb_pd_sink_connection_manager_unit
  import usbpdsnk_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Poll channel
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata, from bit 0: alert_pending, alert_cc_change, alert_rx_message,
  // alert_hard_reset, alert_tx_done, cc_terminated, cc1_level[2],
  // cc2_level[2], msg_type[5], msg_object_count[3], now_us[48], zero pad
  input  logic [InDataW-1:0]  s_tdata,
  // Action channel
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata, from bit 0: clear_alert[3], restart_detection,
  // commit_connection, orientation, send_request, request_object[32],
  // port_state[2], negotiation_state[3], halted, zero pad
  output logic [OutDataW-1:0] m_tdata,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  cfg_t      cfg;
  in_item_t  held_item;
  logic      held_valid;
  logic      take;
  out_item_t res_item;

  usbpdsnk_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  usbpdsnk_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item_t'(s_tdata[InBits-1:0])),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  usbpdsnk_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_item   (res_item)
  );

  // Pack the result beat, zero pad to whole bytes
  assign m_tdata = {{(OutDataW - OutBits){1'b0}}, res_item};

endmodule

// ===== src/usbpdsnk_checker.sv =====
// ----------------------------------------------------------------------------
// usbpdsnk_checker
// Port-level checks on the action channel, bound to the top level.
// ----------------------------------------------------------------------------
module usbpdsnk_checker
  import usbpdsnk_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  out_item_t res;
  assign res = out_item_t'(m_tdata[OutBits-1:0]);

  // A stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat withdrawn while stalled");

  // A halted block requests no action
  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.halted |->
      res.clear_alert == CLR_NONE && !res.restart_detection &&
      !res.commit_connection && !res.send_request)
    else $error("action reported while halted");

  // A commit leaves the port connected
  a_commit_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.commit_connection |-> res.port_state == PORT_CONNECTED)
    else $error("commit without connected port");

  // A request send leaves the negotiation waiting on it
  a_send_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.send_request |->
      res.negotiation_state == NEG_REQUEST_SENT && res.port_state == PORT_CONNECTED)
    else $error("request sent from wrong state");

  // Orientation and object stay zero without their strobes
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (res.commit_connection || !res.orientation) &&
      (res.send_request || res.request_object == '0))
    else $error("qualified field set without its strobe");

endmodule

bind usb_pd_sink_connection_manager_unit usbpdsnk_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/tb_usb_pd_sink_connection_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_pd_sink_connection_manager_unit
// Self-checking bench for the USB PD sink connection manager.
// ----------------------------------------------------------------------------
// Polls go in on the s_ stream and actions are checked on the m_ stream
// against a cycle-free predictor of the port and negotiation state machines.
// A short directed table opens the run. After it come random phases under
// several register settings, biased towards full attach / negotiate / detach
// sequences. The run ends by steering the port into the sticky halt and
// polling it a few more times. Both stream sides idle at random. One long
// receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_usb_pd_sink_connection_manager_unit;
  import usbpdsnk_pkg::*;

  localparam logic [TimeW-1:0] TimeMax       = '1;
  localparam int unsigned      CycleLimit    = 400000;
  localparam int unsigned      HoldCycles    = 400;
  localparam int unsigned      ResultLatency = 4;

  // One row of the directed table
  typedef struct {
    in_item_t  poll;
    bit        typed;
    out_item_t want;
  } row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  // s_tdata, from bit 0: alert_pending, alert_cc_change, alert_rx_message,
  // alert_hard_reset, alert_tx_done, cc_terminated, cc1_level[2],
  // cc2_level[2], msg_type[5], msg_object_count[3], now_us[48], zero pad
  logic [InDataW-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  // m_tdata, from bit 0: clear_alert[3], restart_detection,
  // commit_connection, orientation, send_request, request_object[32],
  // port_state[2], negotiation_state[3], halted, zero pad
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  // Predictor state and register copies
  port_mode_t        port_mode;
  neg_mode_t         contract_mode;
  logic [TimeW-1:0]  event_stamp;
  bit                halted_flag;
  logic [DelayW-1:0] connect_delay;
  logic [DelayW-1:0] disconnect_delay;
  logic [DelayW-1:0] request_delay;
  logic [ObjW-1:0]   request_dobj;

  // Stimulus time base and bookkeeping
  logic [TimeW-1:0] clock_us;
  out_item_t        due_actions[$];
  out_item_t        seen_action;
  out_item_t        due_action;
  int unsigned      action_beats;
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  int unsigned      hold_count;
  bit               steady_run;

  usb_pd_sink_connection_manager_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timer has run out once now passes stamp plus delay, sum kept wide
  function automatic bit deadline_passed(input logic [TimeW-1:0] now,
                                         input logic [DelayW-1:0] delay);
    logic [63:0] limit;
    limit = {16'd0, event_stamp} + {40'd0, delay};
    return {16'd0, now} > limit;
  endfunction

  // Advance the predictor by one poll and return the action it causes
  function automatic out_item_t predict_action(input in_item_t p);
    out_item_t a;
    a = '0;
    if (!halted_flag) begin
      if (p.alert_pending) begin
        if (p.alert_cc_change) begin
          case (port_mode)
            PORT_DISCONNECTED: begin
              if (p.cc_terminated) begin
                port_mode     = PORT_ATTACH_DEB;
                event_stamp   = p.now_us;
                a.clear_alert = CLR_CC;
              end else begin
                halted_flag = 1'b1;
              end
            end
            PORT_ATTACH_DEB: begin
              port_mode           = PORT_DISCONNECTED;
              contract_mode       = NEG_IDLE;
              a.restart_detection = 1'b1;
              a.clear_alert       = CLR_CC;
            end
            PORT_CONNECTED: begin
              port_mode     = PORT_DETACH_DEB;
              event_stamp   = p.now_us;
              a.clear_alert = CLR_CC;
            end
            default: a.clear_alert = CLR_CC;
          endcase
        end else if (p.alert_rx_message) begin
          // Messages only count once connected; otherwise left pending
          if (port_mode == PORT_CONNECTED) begin
            a.clear_alert = CLR_RX;
            if (p.msg_object_count != 3'd0 && p.msg_type == MsgSourceCap) begin
              contract_mode = NEG_CAPS_RECEIVED;
              event_stamp   = p.now_us;
            end else if (contract_mode == NEG_WAIT_ACCEPT && p.msg_object_count == 3'd0
                         && p.msg_type == MsgAccept) begin
              contract_mode = NEG_WAIT_READY;
            end else if (contract_mode == NEG_WAIT_READY && p.msg_object_count == 3'd0
                         && p.msg_type == MsgPsReady) begin
              contract_mode = NEG_READY;
            end
          end
        end else if (p.alert_hard_reset) begin
          if (port_mode == PORT_CONNECTED) a.clear_alert = CLR_HARD_RESET;
        end else if (p.alert_tx_done) begin
          a.clear_alert = CLR_TX_DONE;
          if (port_mode == PORT_CONNECTED && contract_mode == NEG_REQUEST_SENT) begin
            contract_mode = NEG_WAIT_ACCEPT;
          end
        end
      end
      // Timers, checked after the alert in the same poll
      if (!halted_flag) begin
        case (port_mode)
          PORT_ATTACH_DEB: begin
            if (deadline_passed(p.now_us, connect_delay)) begin
              port_mode           = PORT_CONNECTED;
              a.commit_connection = 1'b1;
              a.orientation       = (p.cc2_level > 2'd1);
            end
          end
          PORT_DETACH_DEB: begin
            if (deadline_passed(p.now_us, disconnect_delay)) port_mode = PORT_DISCONNECTED;
          end
          PORT_CONNECTED: begin
            if (contract_mode == NEG_CAPS_RECEIVED && deadline_passed(p.now_us, request_delay)) begin
              contract_mode    = NEG_REQUEST_SENT;
              a.send_request   = 1'b1;
              a.request_object = request_dobj;
            end
          end
          default: ;
        endcase
      end
    end
    a.port_state        = port_mode;
    a.negotiation_state = contract_mode;
    a.halted            = halted_flag;
    return a;
  endfunction

  function automatic in_item_t mk_poll(input bit pend, input bit cc, input bit rx,
                                       input bit hr, input bit tx, input bit term,
                                       input logic [1:0] cc1, input logic [1:0] cc2,
                                       input logic [4:0] mtype, input logic [2:0] mcnt,
                                       input logic [TimeW-1:0] now);
    in_item_t p;
    p.alert_pending    = pend;
    p.alert_cc_change  = cc;
    p.alert_rx_message = rx;
    p.alert_hard_reset = hr;
    p.alert_tx_done    = tx;
    p.cc_terminated    = term;
    p.cc1_level        = cc1;
    p.cc2_level        = cc2;
    p.msg_type         = mtype;
    p.msg_object_count = mcnt;
    p.now_us           = now;
    return p;
  endfunction

  function automatic out_item_t mk_action(input clear_t clr, input bit restart,
                                          input bit commit, input bit orient,
                                          input bit send, input logic [ObjW-1:0] obj,
                                          input port_mode_t port, input neg_mode_t neg,
                                          input bit halt);
    out_item_t a;
    a.clear_alert       = clr;
    a.restart_detection = restart;
    a.commit_connection = commit;
    a.orientation       = orient;
    a.send_request      = send;
    a.request_object    = obj;
    a.port_state        = port;
    a.negotiation_state = neg;
    a.halted            = halt;
    return a;
  endfunction

  // Pick the next poll: mostly the step that moves the port on, else noise
  function automatic in_item_t next_poll();
    in_item_t    p;
    logic [31:0] r;
    logic [63:0] t;
    int unsigned roll;
    int unsigned span;
    bit          timed;
    bit          jump;
    r     = $urandom;
    t     = {$urandom, $urandom};
    roll  = $urandom_range(0, 99);
    timed = 1'b0;
    jump  = 1'b0;
    span  = 0;
    p.alert_pending    = r[0];
    p.alert_cc_change  = r[1];
    p.alert_rx_message = r[2];
    p.alert_hard_reset = r[3];
    p.alert_tx_done    = r[4];
    p.cc_terminated    = r[5];
    p.cc1_level        = r[7:6];
    p.cc2_level        = r[9:8];
    p.msg_type         = r[14:10];
    p.msg_object_count = r[17:15];
    p.now_us           = clock_us + $urandom_range(0, 3000);
    if (roll < 70) begin
      case (port_mode)
        PORT_DISCONNECTED: begin
          p.alert_pending   = 1'b1;
          p.alert_cc_change = 1'b1;
          p.cc_terminated   = 1'b1;
        end
        PORT_ATTACH_DEB: begin
          p.alert_cc_change = 1'b0;
          timed             = 1'b1;
          span              = connect_delay;
        end
        PORT_CONNECTED: begin
          p.alert_pending   = 1'b1;
          p.alert_cc_change = 1'b0;
          case (contract_mode)
            NEG_CAPS_RECEIVED: begin
              p.alert_pending    = r[0];
              p.alert_rx_message = 1'b0;
              timed              = 1'b1;
              span               = request_delay;
            end
            NEG_REQUEST_SENT: begin
              p.alert_rx_message = 1'b0;
              p.alert_hard_reset = 1'b0;
              p.alert_tx_done    = 1'b1;
            end
            NEG_WAIT_ACCEPT: begin
              p.alert_rx_message = 1'b1;
              p.msg_type         = MsgAccept;
              p.msg_object_count = 3'd0;
            end
            NEG_WAIT_READY: begin
              p.alert_rx_message = 1'b1;
              p.msg_type         = MsgPsReady;
              p.msg_object_count = 3'd0;
            end
            default: begin
              // Fresh capabilities, or unplug once the contract stands
              p.alert_cc_change  = r[20] & (contract_mode == NEG_READY);
              p.alert_rx_message = 1'b1;
              p.msg_type         = MsgSourceCap;
              p.msg_object_count = r[17:15] | 3'd1;
            end
          endcase
        end
        default: begin
          timed = 1'b1;
          span  = disconnect_delay;
        end
      endcase
    end else if (roll >= 96 && !p.alert_pending) begin
      // Jump anywhere in time; no stamp is taken, so the time base stays put
      p.now_us = t[TimeW-1:0];
      jump     = 1'b1;
    end
    // Land on either side of the running timer's deadline
    if (timed) begin
      t = {16'd0, event_stamp} + (span / 2) + $urandom_range(0, span + 2);
      if (t > {16'd0, TimeMax}) t = {16'd0, TimeMax};
      p.now_us = t[TimeW-1:0];
    end
    // Keep the halt for the closing phase
    if (port_mode == PORT_DISCONNECTED && p.alert_pending && p.alert_cc_change) begin
      p.cc_terminated = 1'b1;
    end
    if (!jump) clock_us = p.now_us;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatch_count++;
    if (mismatch_count <= 200) begin
      $display("ERROR beat %0d: %s got 0x%0h expected 0x%0h", action_beats, what, got, want);
    end
  endtask

  // Offer one poll, with random gaps, and hold it until it is taken
  task automatic drive_poll(input in_item_t p, input out_item_t want);
    while (!steady_run && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW - InBits){1'b0}}, p};
    do @(posedge clk); while (!s_tready);
    due_actions.push_back(want);
  endtask

  task automatic run_polls(input int unsigned count);
    in_item_t p;
    for (int unsigned n = 0; n < count; n++) begin
      p = next_poll();
      drive_poll(p, predict_action(p));
    end
  endtask

  // Drop valid and wait for every outstanding action to drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_actions.size() != 0) @(posedge clk);
    repeat (ResultLatency) @(posedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic apply_settings(input logic [DelayW-1:0] conn, input logic [DelayW-1:0] disc,
                                input logic [DelayW-1:0] req, input logic [ObjW-1:0] obj);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CONNECT_DEBOUNCE;
    cfg_data  <= {8'd0, conn};
    @(posedge clk);
    cfg_index <= CFG_DISCONNECT_DEBOUNCE;
    cfg_data  <= {8'd0, disc};
    @(posedge clk);
    cfg_index <= CFG_REQUEST_DELAY;
    cfg_data  <= {8'd0, req};
    @(posedge clk);
    cfg_index <= CFG_REQUEST_OBJECT;
    cfg_data  <= obj;
    @(posedge clk);
    cfg_we <= 1'b0;
    connect_delay    = conn;
    disconnect_delay = disc;
    request_delay    = req;
    request_dobj     = obj;
    @(posedge clk);
  endtask

  // Receiver: random stalls, a stall-free stretch, and one long hold-off
  initial begin
    m_tready   = 1'b0;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (hold_count == 0 && action_beats >= 1000) begin
        m_tready <= 1'b0;
        for (hold_count = 1; hold_count < HoldCycles; hold_count++) @(posedge clk);
      end else begin
        m_tready <= steady_run || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // Compare each action beat with the oldest prediction
  initial action_beats = 0;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      action_beats++;
      seen_action = m_tdata[OutBits-1:0];
      if (due_actions.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata[OutBits-1:0], 48'd0);
      end else begin
        due_action = due_actions.pop_front();
        if (seen_action.clear_alert !== due_action.clear_alert)
          report_mismatch("clear_alert", seen_action.clear_alert, due_action.clear_alert);
        if (seen_action.restart_detection !== due_action.restart_detection)
          report_mismatch("restart_detection", seen_action.restart_detection,
                          due_action.restart_detection);
        if (seen_action.commit_connection !== due_action.commit_connection)
          report_mismatch("commit_connection", seen_action.commit_connection,
                          due_action.commit_connection);
        if (seen_action.orientation !== due_action.orientation)
          report_mismatch("orientation", seen_action.orientation, due_action.orientation);
        if (seen_action.send_request !== due_action.send_request)
          report_mismatch("send_request", seen_action.send_request, due_action.send_request);
        if (seen_action.request_object !== due_action.request_object)
          report_mismatch("request_object", seen_action.request_object,
                          due_action.request_object);
        if (seen_action.port_state !== due_action.port_state)
          report_mismatch("port_state", seen_action.port_state, due_action.port_state);
        if (seen_action.negotiation_state !== due_action.negotiation_state)
          report_mismatch("negotiation_state", seen_action.negotiation_state,
                          due_action.negotiation_state);
        if (seen_action.halted !== due_action.halted)
          report_mismatch("halted", seen_action.halted, due_action.halted);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Main sequence
  initial begin
    row_t        plan [26];
    out_item_t   want;
    in_item_t    p;
    int unsigned waited;

    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    steady_run     = 1'b0;
    mismatch_count = 0;
    port_mode        = PORT_DISCONNECTED;
    contract_mode    = NEG_IDLE;
    event_stamp      = '0;
    halted_flag      = 1'b0;
    connect_delay    = ConnectDebounceRst;
    disconnect_delay = DisconnectDebounceRst;
    request_delay    = RequestDelayRst;
    request_dobj     = RequestObjectRst;
    clock_us         = 48'd1000000;

    // Directed table, register defaults
    // idle poll straight after reset
    plan[0]  = '{mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 48'd0), 1'b1,
                 mk_action(CLR_NONE, 0, 0, 0, 0, 0, PORT_DISCONNECTED, NEG_IDLE, 0)};
    // rx while disconnected: left pending, and it masks hard reset and tx
    plan[1]  = '{mk_poll(1, 0, 1, 1, 1, 0, 0, 0, 0, 0, 48'd10), 1'b1,
                 mk_action(CLR_NONE, 0, 0, 0, 0, 0, PORT_DISCONNECTED, NEG_IDLE, 0)};
    // hard reset while disconnected masks tx
    plan[2]  = '{mk_poll(1, 0, 0, 1, 1, 0, 0, 0, 0, 0, 48'd20), 1'b1,
                 mk_action(CLR_NONE, 0, 0, 0, 0, 0, PORT_DISCONNECTED, NEG_IDLE, 0)};
    // tx done is cleared in any port state
    plan[3]  = '{mk_poll(1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 48'd30), 1'b1,
                 mk_action(CLR_TX_DONE, 0, 0, 0, 0, 0, PORT_DISCONNECTED, NEG_IDLE, 0)};
    // alert bits without the interrupt line are ignored, no halt
    plan[4]  = '{mk_poll(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 48'd40), 1'b1,
                 mk_action(CLR_NONE, 0, 0, 0, 0, 0, PORT_DISCONNECTED, NEG_IDLE, 0)};
    // terminated CC change starts the attach debounce
    plan[5]  = '{mk_poll(1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 48'd100), 1'b1,
                 mk_action(CLR_CC, 0, 0, 0, 0, 0, PORT_ATTACH_DEB, NEG_IDLE, 0)};
    // exactly at the deadline: not yet
    plan[6]  = '{mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 48'd150100), 1'b1,
                 mk_action(CLR_NONE, 0, 0, 0, 0, 0, PORT_ATTACH_DEB, NEG_IDLE, 0)};
    // one past: commit on CC1 (cc2 level 1 does not count)
    plan[7]  = '{mk_poll(0, 0, 0, 0, 0, 0, 3, 1, 0, 0, 48'd150101), 1'b1,
                 mk_action(CLR_NONE, 0, 1, 0, 0, 0, PORT_CONNECTED, NEG_IDLE, 0)};
    // source capabilities
    plan[8]  = '{mk_poll(1, 0, 1, 0, 0, 0, 0, 0, MsgSourceCap, 2, 48'd200000), 1'b1,
                 mk_action(CLR_RX, 0, 0, 0, 0, 0, PORT_CONNECTED, NEG_CAPS_RECEIVED, 0)};
    // hard reset while connected is cleared only
    plan[9]  = '{mk_poll(1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 48'd200500), 1'b1,
                 mk_action(CLR_HARD_RESET, 0, 0, 0, 0, 0, PORT_CONNECTED, NEG_CAPS_RECEIVED, 0)};
    // request delay at the deadline, then one past it
    plan[10] = '{mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 48'd201000), 1'b1,
                 mk_action(CLR_NONE, 0, 0, 0, 0, 0, PORT_CONNECTED, NEG_CAPS_RECEIVED, 0)};
    plan[11] = '{mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 48'd201001), 1'b1,
                 mk_action(CLR_NONE, 0, 0, 0, 1, RequestObjectRst, PORT_CONNECTED,
                           NEG_REQUEST_SENT, 0)};
    plan[12] = '{mk_poll(1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 48'd201002), 1'b1,
                 mk_action(CLR_TX_DONE, 0, 0, 0, 0, 0, PORT_CONNECTED, NEG_WAIT_ACCEPT, 0)};
    // accept carrying data objects is not an accept
    plan[13] = '{mk_poll(1, 0, 1, 0, 0, 0, 0, 0, MsgAccept, 1, 48'd201100), 1'b0, '0};
    plan[14] = '{mk_poll(1, 0, 1, 0, 0, 0, 0, 0, MsgAccept, 0, 48'd201200), 1'b0, '0};
    plan[15] = '{mk_poll(1, 0, 1, 0, 0, 0, 0, 0, MsgPsReady, 0, 48'd201300), 1'b0, '0};
    // unplug, CC change inside the detach debounce, then debounce end
    plan[16] = '{mk_poll(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 48'd300000), 1'b0, '0};
    plan[17] = '{mk_poll(1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 48'd320000), 1'b0, '0};
    plan[18] = '{mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 48'd350001), 1'b0, '0};
    // attach, then every field at its top: CC change aborts the attach
    plan[19] = '{mk_poll(1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 48'd400000), 1'b0, '0};
    plan[20] = '{mk_poll(1, 1, 1, 1, 1, 1, 3, 3, 5'd31, 3'd7, TimeMax), 1'b1,
                 mk_action(CLR_CC, 1, 0, 0, 0, 0, PORT_DISCONNECTED, NEG_IDLE, 0)};
    // stamp near the top of time: deadline sum must not wrap
    plan[21] = '{mk_poll(1, 1, 0, 0, 0, 1, 0, 0, 0, 0, TimeMax - 48'd1000), 1'b0, '0};
    plan[22] = '{mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, TimeMax), 1'b0, '0};
    plan[23] = '{mk_poll(1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 48'd500000), 1'b0, '0};
    // reattach and commit on CC2
    plan[24] = '{mk_poll(1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 48'd600000), 1'b0, '0};
    plan[25] = '{mk_poll(0, 0, 0, 0, 0, 0, 0, 2, 0, 0, 48'd750001), 1'b0, '0};

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 26; i++) begin
      want = predict_action(plan[i].poll);
      if (plan[i].typed) want = plan[i].want;
      drive_poll(plan[i].poll, want);
    end
    settle();

    // Random phases under several register settings
    run_polls(300);
    settle();
    apply_settings(24'd0, 24'd0, 24'd0, 32'd0);
    steady_run = 1'b1;
    run_polls(300);
    settle();
    steady_run = 1'b0;
    apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
    run_polls(300);
    settle();
    apply_settings($urandom_range(1, 5000), $urandom_range(1, 5000),
                   $urandom_range(1, 2000), $urandom);
    run_polls(400);
    settle();
    apply_settings($urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
                   $urandom_range(0, 24'hFF_FFFF), $urandom);
    run_polls(350);

    // Steer the port back to disconnected and halt it with an open CC
    while (!halted_flag) begin
      p = mk_poll(1, 1, 0, 0, 0, 1, 0, 0, 0, 0, clock_us + 48'd10);
      case (port_mode)
        PORT_DISCONNECTED: p.cc_terminated = 1'b0;
        PORT_DETACH_DEB: begin
          p.alert_pending = 1'b0;
          p.now_us        = event_stamp + disconnect_delay + 48'd1;
        end
        default: ;
      endcase
      clock_us = p.now_us;
      drive_poll(p, predict_action(p));
    end
    run_polls(12);

    // Drain, then let the pipeline run empty before the last check
    s_tvalid <= 1'b0;
    waited = 0;
    while (due_actions.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (ResultLatency * 2) @(posedge clk);
    if (due_actions.size() != 0) report_mismatch("missing beats", 48'd0, due_actions.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== usb_pd_sink_connection_manager_unit.f =====
src/usbpdsnk_pkg.sv
src/usbpdsnk_cfg.sv
src/usbpdsnk_in_reg.sv
src/usbpdsnk_core.sv
src/usb_pd_sink_connection_manager_unit.sv
src/usbpdsnk_checker.sv
bench/tb_usb_pd_sink_connection_manager_unit.sv
